// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the telemetry decoder.
// Each macro expects clk and rst in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bdt_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and the GCR lookup for the telemetry decoder.
// No dependencies.
package bdt_pkg;

  localparam int QUO_W  = 26;
  localparam int MANT_W = 9;
  localparam int PP_W   = 7;

  localparam logic [QUO_W-1:0]  ERPM_NUMERATOR    = 26'd60000000;
  localparam logic [PP_W-1:0]   ROTOR_PAIRS_RESET = 7'd7;
  localparam logic [MANT_W-1:0] MANT_NO_SPIN      = 9'h1FF;
  localparam logic [3:0]        EDT_VOLTAGE       = 4'h4;
  localparam logic [15:0]       RPM_MAX           = 16'hFFFF;
  localparam logic              REG_ROTOR_PAIRS   = 1'b0;

  typedef enum logic [2:0] {
    ST_ERPM        = 3'd0,
    ST_EDT         = 3'd1,
    ST_BAD_GCR     = 3'd2,
    ST_BAD_CRC     = 3'd3,
    ST_ZERO_PERIOD = 3'd4
  } status_t;

  typedef struct packed {
    logic              gcr_ok;
    logic [15:0]       frame;
    status_t           status;
    logic [3:0]        edt_type;
    logic [9:0]        edt_value;
    logic              use_q;
    logic [QUO_W-1:0]  num;
    logic [MANT_W-1:0] rem;
    logic [MANT_W-1:0] den;
    logic [QUO_W-1:0]  erpm;
    logic [15:0]       rpm;
  } stage_t;

  // bit 4 set marks a listed group, bits 3..0 carry the nibble
  function automatic logic [4:0] gcr_lookup(input logic [4:0] grp);
    logic [4:0] e;
    case (grp)
      5'h09:   e = 5'h19;
      5'h0A:   e = 5'h1A;
      5'h0B:   e = 5'h1B;
      5'h0D:   e = 5'h1D;
      5'h0E:   e = 5'h1E;
      5'h0F:   e = 5'h1F;
      5'h12:   e = 5'h12;
      5'h13:   e = 5'h13;
      5'h15:   e = 5'h15;
      5'h16:   e = 5'h16;
      5'h17:   e = 5'h17;
      5'h19:   e = 5'h10;
      5'h1A:   e = 5'h18;
      5'h1B:   e = 5'h11;
      5'h1D:   e = 5'h14;
      5'h1E:   e = 5'h1C;
      default: e = 5'h00;
    endcase
    return e;
  endfunction

endpackage

// ----- hw/rtl/bdshot_telemetry_decoder_top.sv -----
`timescale 1ns / 1ps
// Bidirectional DShot telemetry word decoder: GCR decode, CRC check, eRPM, rpm and EDT.
// Depends on bdt_pkg and assert_macros.svh.
//
//  port group   | role      | handshake
//  -------------+-----------+-----------------------------------
//  raw_bits     | in        | in_valid / in_ready
//  result       | out       | out_valid / out_ready
//  rotor_pairs  | config    | APB write at byte address 0
//
// One transaction per cycle while out_ready is high. Decode and classify stages feed
// two radix 2**RADIX_BITS division chains, eRPM then rpm, each ending in a finish stage.
// Reset clears all stage valid bits and loads rotor_pairs with 7.
// A full stage holds while the stage after it holds; empty stages close up under stall.
`include "assert_macros.svh"

module bdshot_telemetry_decoder_top import bdt_pkg::*; #(
  parameter int RADIX_BITS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] raw_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] decoded_frame,
  output logic [25:0] erpm,
  output logic [15:0] rpm,
  output logic [3:0]  edt_type,
  output logic [9:0]  edt_value
);

  localparam int DIV_STG = (QUO_W + RADIX_BITS - 1) / RADIX_BITS;
  localparam int NSTG    = 4 + 2 * DIV_STG;
  localparam int LAST    = NSTG - 1;

  logic [PP_W-1:0] rotor_pairs;

  stage_t          pipe [NSTG];
  stage_t          nxt  [NSTG];
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  function automatic stage_t decode(input logic [19:0] word);
    logic [19:0] gcr;
    logic [4:0]  e;
    stage_t      r;
    gcr         = word ^ (word >> 1);
    r           = '0;
    r.status    = ST_ERPM;
    r.gcr_ok    = 1'b1;
    for (int g = 0; g < 4; g++) begin
      e = gcr_lookup(gcr[15-5*g +: 5]);
      r.gcr_ok = r.gcr_ok & e[4];
      r.frame[12-4*g +: 4] = e[3:0];
    end
    return r;
  endfunction

  function automatic stage_t classify(input stage_t s);
    logic [11:0]       data;
    logic [3:0]        crc;
    logic [2:0]        expo;
    logic [MANT_W-1:0] mant;
    stage_t            r;
    data        = s.frame[15:4];
    crc         = ~(data[3:0] ^ data[7:4] ^ data[11:8]);
    expo        = data[11:9];
    mant        = data[8:0];
    r           = s;
    r.edt_type  = '0;
    r.edt_value = '0;
    r.use_q     = 1'b0;
    r.rem       = '0;
    r.den       = mant;
    r.num       = ERPM_NUMERATOR >> expo;
    r.erpm      = '0;
    r.rpm       = '0;
    if (!s.gcr_ok) begin
      r.status = ST_BAD_GCR;
      r.frame  = '0;
    end else if (crc != s.frame[3:0]) begin
      r.status = ST_BAD_CRC;
    end else if (mant == '0) begin
      r.status = ST_ZERO_PERIOD;
    end else if (!expo[0] && !mant[MANT_W-1]) begin
      r.status   = ST_EDT;
      r.edt_type = data[11:8];
      if (data[11:8] == EDT_VOLTAGE) begin
        r.edt_value = {data[7:0], 2'b00};
      end else begin
        r.edt_value = {2'b00, data[7:0]};
      end
    end else begin
      r.status = ST_ERPM;
      r.use_q  = (mant != MANT_NO_SPIN);
    end
    return r;
  endfunction

  // up to RADIX_BITS restoring steps; num shifts out dividend bits and takes in quotient bits
  function automatic stage_t div_step(input stage_t s, input int base);
    logic [MANT_W:0] rem2;
    logic            ge;
    stage_t          r;
    r = s;
    for (int j = 0; j < RADIX_BITS; j++) begin
      if (base + j < QUO_W) begin
        rem2  = {r.rem, r.num[QUO_W-1]};
        ge    = (rem2 >= {1'b0, r.den});
        r.num = {r.num[QUO_W-2:0], ge};
        r.rem = ge ? MANT_W'(rem2 - {1'b0, r.den}) : rem2[MANT_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic stage_t erpm_done(input stage_t s, input logic [PP_W-1:0] pp);
    stage_t r;
    r      = s;
    r.erpm = s.use_q ? s.num : '0;
    r.num  = r.erpm;
    r.rem  = '0;
    r.den  = {{(MANT_W-PP_W){1'b0}}, pp};
    return r;
  endfunction

  function automatic stage_t rpm_done(input stage_t s, input logic [PP_W-1:0] pp);
    stage_t r;
    r = s;
    if (s.erpm == '0) begin
      r.rpm = '0;
    end else if (pp == '0 || s.num > {{(QUO_W-16){1'b0}}, RPM_MAX}) begin
      r.rpm = RPM_MAX;
    end else begin
      r.rpm = s.num[15:0];
    end
    return r;
  endfunction

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROTOR_PAIRS) ? {{(32-PP_W){1'b0}}, rotor_pairs} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotor_pairs <= ROTOR_PAIRS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROTOR_PAIRS) begin
      rotor_pairs <= pwdata[PP_W-1:0];
    end
  end

  // stage advance: load when empty or when the stage after moves on
  always_comb begin
    adv[LAST] = !vld[LAST] || out_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    if (g == 0) begin : g_dec
      assign nxt[g] = decode(raw_bits);
    end else if (g == 1) begin : g_cls
      assign nxt[g] = classify(pipe[g-1]);
    end else if (g < 2 + DIV_STG) begin : g_ediv
      assign nxt[g] = div_step(pipe[g-1], (g - 2) * RADIX_BITS);
    end else if (g == 2 + DIV_STG) begin : g_efin
      assign nxt[g] = erpm_done(pipe[g-1], rotor_pairs);
    end else if (g < 3 + 2 * DIV_STG) begin : g_rdiv
      assign nxt[g] = div_step(pipe[g-1], (g - 3 - DIV_STG) * RADIX_BITS);
    end else begin : g_rfin
      assign nxt[g] = rpm_done(pipe[g-1], rotor_pairs);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (adv[g]) begin
        vld[g] <= (g == 0) ? in_valid : vld[(g == 0) ? 0 : g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[g]) begin
        pipe[g] <= nxt[g];
      end
    end
  end

  assign out_valid     = vld[LAST];
  assign status        = pipe[LAST].status;
  assign decoded_frame = pipe[LAST].frame;
  assign erpm          = pipe[LAST].erpm;
  assign rpm           = pipe[LAST].rpm;
  assign edt_type      = pipe[LAST].edt_type;
  assign edt_value     = pipe[LAST].edt_value;

  `BDT_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, vld[0], "accepted word lost at entry")
  `BDT_ASSERT_NOW(a_bad_gcr_frame, out_valid && status == ST_BAD_GCR,
    decoded_frame == '0 && erpm == '0 && rpm == '0, "bad GCR result not cleared")
  `BDT_ASSERT_NOW(a_speed_only_erpm, out_valid && status != ST_ERPM,
    erpm == '0 && rpm == '0, "speed fields set outside eRPM frame")
  `BDT_ASSERT_NOW(a_rpm_zero, out_valid && erpm == '0, rpm == '0,
    "rpm nonzero with zero eRPM")
  `BDT_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready,
    out_valid && $stable(erpm) && $stable(rpm), "held result changed under stall")

endmodule

// ----- sim/bdt_telemetry_checker.sv -----
`timescale 1ns / 1ps
// Checker for the telemetry decoder: watches the input, output and config channels,
// predicts each result from the captured word and compares it. Depends on bdt_pkg.
module bdt_telemetry_checker import bdt_pkg::*; #(
  parameter logic [79:0] GCR_CODES = '0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [19:0] raw_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [15:0] decoded_frame,
  input  logic [25:0] erpm,
  input  logic [15:0] rpm,
  input  logic [3:0]  edt_type,
  input  logic [9:0]  edt_value,
  output int          mismatches,
  output int          pending
);

  localparam logic [2:0] PP_ADDR = {REG_ROTOR_PAIRS, 2'b00};

  typedef struct packed {
    status_t     status;
    logic [15:0] frame;
    logic [25:0] erpm;
    logic [15:0] rpm;
    logic [3:0]  edt_type;
    logic [9:0]  edt_value;
  } telem_t;

  telem_t          expected_telem[$];
  logic [PP_W-1:0] rotor_pairs_now;
  int              results_seen;

  function automatic telem_t decode_line_word(input logic [19:0] w, input logic [PP_W-1:0] pp);
    telem_t      r;
    logic [19:0] groups;
    logic [4:0]  grp;
    logic [11:0] data;
    logic [3:0]  crc;
    logic [16:0] period;
    logic [25:0] q;
    logic        listed;
    logic        all_listed;
    int          g;
    int          n;
    r = '0;
    groups = w ^ (w >> 1);
    all_listed = 1'b1;
    for (g = 3; g >= 0; g--) begin
      grp = groups[5*g +: 5];
      listed = 1'b0;
      for (n = 0; n < 16; n++) begin
        if (GCR_CODES[5*n +: 5] == grp) begin
          listed = 1'b1;
          r.frame[4*g +: 4] = 4'(n);
        end
      end
      all_listed = all_listed & listed;
    end
    if (!all_listed) begin
      r = '0;
      r.status = ST_BAD_GCR;
      return r;
    end
    data = r.frame[15:4];
    crc = ~(data[11:8] ^ data[7:4] ^ data[3:0]);
    if (r.frame[3:0] != crc) begin
      r.status = ST_BAD_CRC;
    end else if (data[8:0] == '0) begin
      r.status = ST_ZERO_PERIOD;
    end else if (!data[9] && !data[8]) begin
      r.status = ST_EDT;
      r.edt_type = data[11:8];
      r.edt_value = (data[11:8] == EDT_VOLTAGE) ? {data[7:0], 2'b00} : {2'b00, data[7:0]};
    end else begin
      r.status = ST_ERPM;
      period = 17'(data[8:0]) << data[11:9];
      if (data[8:0] != MANT_NO_SPIN) r.erpm = ERPM_NUMERATOR / 26'(period);
      if (r.erpm == '0) begin
        r.rpm = '0;
      end else if (pp == '0) begin
        r.rpm = RPM_MAX;
      end else begin
        q = r.erpm / 26'(pp);
        r.rpm = (q > 26'(RPM_MAX)) ? RPM_MAX : q[15:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    telem_t want;
    if (rst) begin
      rotor_pairs_now = ROTOR_PAIRS_RESET;
      expected_telem.delete();
      mismatches <= 0;
      results_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == PP_ADDR)
        rotor_pairs_now = pwdata[PP_W-1:0];
      if (in_valid && in_ready)
        expected_telem.push_back(decode_line_word(raw_bits, rotor_pairs_now));
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_telem.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with nothing expected: status=%0d frame=%h",
                     results_seen, status, decoded_frame);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_telem.pop_front();
          if (status != want.status || decoded_frame != want.frame || erpm != want.erpm ||
              rpm != want.rpm || edt_type != want.edt_type || edt_value != want.edt_value) begin
            if (mismatches < 10) begin
              $display("result %0d expected status=%0d frame=%h erpm=%0d rpm=%0d type=%h value=%0d",
                       results_seen, want.status, want.frame, want.erpm, want.rpm,
                       want.edt_type, want.edt_value);
              $display("result %0d got      status=%0d frame=%h erpm=%0d rpm=%0d type=%h value=%0d",
                       results_seen, status, decoded_frame, erpm, rpm, edt_type, edt_value);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= expected_telem.size();
  end

endmodule

// ----- sim/bdshot_telemetry_decoder_top_test.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for bdshot_telemetry_decoder_top: directed and random line words,
// pole pair settings and handshake idling. Depends on bdt_pkg and bdt_telemetry_checker.
module bdshot_telemetry_decoder_top_test;
  import bdt_pkg::*;

  localparam logic [2:0] PP_ADDR    = {REG_ROTOR_PAIRS, 2'b00};
  localparam int         HOLD_LEN   = 300;
  localparam int         IDLE_LIMIT = 3000;
  localparam int         SETTLE     = 40;
  localparam int         PHASES     = 8;
  localparam int         PHASE_LEN  = 140;
  // 5-bit line group for each nibble, nibble 0 in the low bits
  localparam logic [79:0] GCR_CODES = {5'h0F, 5'h0E, 5'h0D, 5'h1E, 5'h0B, 5'h0A, 5'h09, 5'h1A,
                                       5'h17, 5'h16, 5'h15, 5'h1D, 5'h13, 5'h12, 5'h1B, 5'h19};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [19:0] raw_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] decoded_frame;
  logic [25:0] erpm;
  logic [15:0] rpm;
  logic [3:0]  edt_type;
  logic [9:0]  edt_value;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  bdshot_telemetry_decoder_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .raw_bits(raw_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .decoded_frame(decoded_frame), .erpm(erpm), .rpm(rpm),
    .edt_type(edt_type), .edt_value(edt_value)
  );

  bdt_telemetry_checker #(.GCR_CODES(GCR_CODES)) telem_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .raw_bits(raw_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .decoded_frame(decoded_frame), .erpm(erpm), .rpm(rpm),
    .edt_type(edt_type), .edt_value(edt_value),
    .mismatches(mismatches), .pending(pending)
  );

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_asks != hold_served) begin
      hold_served++;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("bdshot_telemetry_decoder_top_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // frame of 12 data bits and its check nibble, xor'ed with crc_flip, in line coding
  function automatic logic [19:0] line_word(input logic [11:0] data, input logic [3:0] crc_flip);
    logic [15:0] frame;
    logic [19:0] groups;
    logic [19:0] w;
    int          i;
    frame = {data, ~(data[11:8] ^ data[7:4] ^ data[3:0]) ^ crc_flip};
    for (i = 0; i < 4; i++)
      groups[5*i +: 5] = GCR_CODES[5*int'(frame[4*i +: 4]) +: 5];
    w[19] = groups[19];
    for (i = 18; i >= 0; i--)
      w[i] = groups[i] ^ w[i+1];
    return w;
  endfunction

  function automatic logic [19:0] random_word();
    logic [11:0] data;
    int          pick;
    int          shape;
    data = 12'($urandom);
    shape = $urandom_range(7);
    if (shape == 0) data[8:0] = MANT_NO_SPIN;
    if (shape == 1) data[8:0] = '0;
    pick = $urandom_range(99);
    if (pick < 65) return line_word(data, 4'h0);
    if (pick < 78) return line_word(data, 4'($urandom_range(15, 1)));
    if (pick < 88) return line_word(data, 4'h0) ^ (20'h1 << $urandom_range(19));
    return 20'($urandom);
  endfunction

  task automatic send_word(input logic [19:0] w);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_bits <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_rotor_pairs(input logic [PP_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PP_ADDR;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    logic [PP_W-1:0] pp_plan [PHASES];
    int              ph;
    int              n;
    pp_plan = '{ROTOR_PAIRS_RESET, 7'd1, 7'd64, 7'd0, 7'd127, 7'($urandom_range(64, 2)), 7'd3,
                7'($urandom_range(64, 1))};
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (ph = 0; ph < PHASES; ph++) begin
      if (in_valid) in_valid <= 1'b0;
      while (pending != 0) @(negedge clk);
      if (ph != 0) write_rotor_pairs(pp_plan[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct = 38;
          recv_stall_pct = 38;
        end
      endcase
      if (ph == 2 || ph == 4) hold_asks++;
      if (ph == 0) begin
        send_word(20'h00000);
        send_word(20'hFFFFF);
        send_word(line_word(12'hFFF, 4'h0));
        send_word(line_word(12'h201, 4'h0));
        send_word(line_word(12'h100, 4'h0));
        send_word(line_word(12'hE01, 4'h0));
        send_word(line_word(12'hFFE, 4'h0));
        send_word(line_word(12'h2FF, 4'h0));
        send_word(line_word(12'h000, 4'h0));
        send_word(line_word(12'h400, 4'h0));
        send_word(line_word(12'h200, 4'h0));
        send_word(line_word(12'h4FF, 4'h0));
        send_word(line_word(12'h401, 4'h0));
        send_word(line_word(12'h012, 4'h0));
        send_word(line_word(12'h8A5, 4'h0));
        send_word(line_word(12'hC7F, 4'h0));
        send_word(line_word(12'h123, 4'h1));
        send_word(line_word(12'hFFF, 4'hF));
        send_word(line_word(12'h5A5, 4'h0) ^ 20'h00001);
        send_word(line_word(12'h3C3, 4'h0) ^ 20'h80000);
      end
      for (n = 0; n < PHASE_LEN; n++)
        send_word(random_word());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("bdshot_telemetry_decoder_top_test: done, clean");
    end else begin
      $display("bdshot_telemetry_decoder_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bdt_pkg.sv
hw/rtl/bdshot_telemetry_decoder_top.sv
sim/bdt_telemetry_checker.sv
sim/bdshot_telemetry_decoder_top_test.sv
